/* design/ecg_heart_rate_detector_unit_defines.svh */
// assertion macros used by the checker file
`ifndef ECG_HEART_RATE_DETECTOR_UNIT_DEFINES_SVH
`define ECG_HEART_RATE_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define EHRD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ehrd check failed: same-cycle rule");

// next-cycle implication, checked outside reset
`define EHRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ehrd check failed: next-cycle rule");

`endif

/* design/ehrd_pkg.sv */
package ehrd_pkg;

    // sample width used by the detector
    localparam int SAMPLE_BITS = 12;
    // threshold register width
    localparam int REG_BITS = 12;
    localparam int TIME_BITS = 32;
    localparam int BPM_BITS = 16;

    // common compare width and signed working threshold width
    localparam int CMP_W = (SAMPLE_BITS > REG_BITS) ? SAMPLE_BITS : REG_BITS;
    localparam int WLT_W = CMP_W + 1;

    // stream payload widths, rounded up to whole bytes
    localparam int IN_DATA_W  = ((SAMPLE_BITS + TIME_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((BPM_BITS + 7) / 8) * 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = REG_BITS;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = CFG_IDX_W'(1);

    localparam logic [REG_BITS-1:0] UPPER_RESET = REG_BITS'(2000);
    localparam logic [REG_BITS-1:0] LOWER_RESET = REG_BITS'(1000);
    localparam logic signed [WLT_W-1:0] FIRST_BEAT_DROP = WLT_W'(700);
    localparam logic [BPM_BITS-1:0] MS_PER_MINUTE = BPM_BITS'(60000);

    // divider step counter
    localparam int DIV_CNT_W = $clog2(BPM_BITS);
    localparam logic [DIV_CNT_W-1:0] DIV_FIRST = DIV_CNT_W'(BPM_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic take_item;
        logic div_step;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_last;
    } dp_stat_t;

endpackage

/* design/ehrd_ctrl.sv */
module ehrd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  ehrd_pkg::dp_stat_t stat,
    output ehrd_pkg::dp_cmd_t  cmd
);
    import ehrd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    // state and output slot registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign slot_free = !out_valid_reg || out_ready;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result slot: filled by the load command, emptied by a transaction
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* design/ehrd_dp.sv */
module ehrd_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ehrd_pkg::dp_cmd_t             cmd,
    output ehrd_pkg::dp_stat_t            stat,
    input  logic [ehrd_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [ehrd_pkg::TIME_BITS-1:0]   time_ms,
    input  logic                          cfg_write,
    input  logic [ehrd_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [ehrd_pkg::CFG_DATA_W-1:0] cfg_val,
    output logic [ehrd_pkg::BPM_BITS-1:0]   bpm,
    output logic                          rate_valid
);
    import ehrd_pkg::*;

    logic [REG_BITS-1:0]     upper_reg;
    logic signed [WLT_W-1:0] wlt_reg;
    logic signed [WLT_W-1:0] wlt_next;
    logic                    in_beat_reg;
    logic                    in_beat_next;
    logic                    first_reg;
    logic                    first_next;
    logic [TIME_BITS-1:0]    last_reg;
    logic [TIME_BITS-1:0]    last_next;
    logic [TIME_BITS-1:0]    interval_reg;
    logic [TIME_BITS-1:0]    interval_next;

    logic [CMP_W-1:0]        s_ext;
    logic signed [WLT_W-1:0] s_signed;
    logic                    rise;
    logic                    beat_mid;
    logic signed [WLT_W-1:0] wlt_mid;

    logic [BPM_BITS-1:0]     rem_reg;
    logic [BPM_BITS-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0]    cnt_reg;
    logic [BPM_BITS:0]       rem_shift;
    logic                    rem_ge;
    logic [BPM_BITS-1:0]     bpm_reg;
    logic                    rate_valid_reg;

    // beat detection for the item on the input
    assign s_ext    = CMP_W'(sample);
    assign s_signed = $signed({1'b0, s_ext});
    assign rise     = (s_ext > CMP_W'(upper_reg)) && !in_beat_reg;
    assign beat_mid = in_beat_reg || rise;
    assign wlt_mid  = (rise && !first_reg) ? (s_signed - FIRST_BEAT_DROP) : wlt_reg;

    always_comb
    begin
        first_next    = first_reg;
        last_next     = last_reg;
        interval_next = interval_reg;
        if (rise)
        begin
            first_next = 1'b1;
            last_next  = time_ms;
            if (first_reg)
            begin
                interval_next = time_ms - last_reg;
            end
        end
        in_beat_next = beat_mid && !(s_signed < wlt_mid);
        wlt_next     = wlt_mid;
    end

    // thresholds and beat state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg    <= UPPER_RESET;
            wlt_reg      <= $signed(WLT_W'(LOWER_RESET));
            in_beat_reg  <= 1'b0;
            first_reg    <= 1'b0;
            last_reg     <= '0;
            interval_reg <= '0;
        end
        else
        begin
            if (cfg_write && (cfg_idx == REG_UPPER))
            begin
                upper_reg <= cfg_val;
            end
            if (cfg_write && (cfg_idx == REG_LOWER))
            begin
                wlt_reg <= $signed(WLT_W'(cfg_val));
            end
            else if (cmd.take_item)
            begin
                wlt_reg <= wlt_next;
            end
            if (cmd.take_item)
            begin
                in_beat_reg  <= in_beat_next;
                first_reg    <= first_next;
                last_reg     <= last_next;
                interval_reg <= interval_next;
            end
        end
    end

    // restoring divider, one quotient bit per cycle, msb first
    assign rem_shift = {rem_reg, MS_PER_MINUTE[cnt_reg]};
    assign rem_ge    = {{(TIME_BITS-BPM_BITS-1){1'b0}}, rem_shift} >= interval_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= DIV_FIRST;
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= BPM_BITS'(rem_shift - interval_reg[BPM_BITS:0]);
            end
            else
            begin
                rem_reg <= rem_shift[BPM_BITS-1:0];
            end
            quo_reg <= {quo_reg[BPM_BITS-2:0], rem_ge};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign stat.div_last = (cnt_reg == '0);

    // result register, zero while no interval is known
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            rate_valid_reg <= (interval_reg != '0);
            bpm_reg        <= (interval_reg != '0) ? quo_reg : '0;
        end
    end

    assign bpm        = bpm_reg;
    assign rate_valid = rate_valid_reg;

endmodule

/* design/ecg_heart_rate_detector_unit.sv */
// an accepted sample runs through the divide state, then the output state loads the result register
// one sample at a time: a new one is taken once the 16-step restoring bpm divider is done and its result is loaded
// the result register lets the next item enter while a result waits to be taken
// reset (rst_n, asynchronous, active low): thresholds 2000 and 1000, no beat seen,
// interval cleared, output empty
module ecg_heart_rate_detector_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ehrd_pkg::IN_DATA_W-1:0]    s_tdata,  // sample, time_ms
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ehrd_pkg::OUT_DATA_W-1:0]   m_tdata,  // bpm
    output logic                              m_tuser,  // rate_valid
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ehrd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ehrd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ehrd_pkg::*;

    dp_cmd_t             cmd;
    dp_stat_t            stat;
    logic [BPM_BITS-1:0] bpm;
    logic                rate_valid;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    ehrd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ehrd_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .sample     (s_tdata[SAMPLE_BITS-1:0]),
        .time_ms    (s_tdata[SAMPLE_BITS +: TIME_BITS]),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_idx    (cfg_index),
        .cfg_val    (cfg_data),
        .bpm        (bpm),
        .rate_valid (rate_valid)
    );

    // output packing
    assign m_tdata = OUT_DATA_W'(bpm);
    assign m_tuser = rate_valid;

endmodule

/* design/ehrd_checker.sv */
`include "ecg_heart_rate_detector_unit_defines.svh"

module ehrd_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ehrd_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tuser,
    input logic                            cfg_ready
);
    import ehrd_pkg::*;

    // a held result stays offered
    `EHRD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    // one item at a time: busy right after a transaction
    `EHRD_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready)
    // no measured interval means a zero rate
    `EHRD_ASSERT_NOW(a_zero_without_rate, m_tvalid && !m_tuser, m_tdata == '0)
    // rate never exceeds one beat per millisecond
    `EHRD_ASSERT_NOW(a_bpm_range, m_tvalid, m_tdata[BPM_BITS-1:0] <= MS_PER_MINUTE)
    // configuration is never back-pressured
    `EHRD_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready)

endmodule

bind ecg_heart_rate_detector_unit ehrd_checker u_ehrd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_ready (cfg_ready)
);

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    import ehrd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTED = 40;
    localparam int SMP_W = 12;
    localparam int TRAIL_W = SMP_W + 1;
    localparam logic signed [TRAIL_W-1:0] BEAT_DROP = TRAIL_W'(700);
    localparam logic [31:0] MINUTE_MS = 32'd60000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
    localparam logic [SMP_W-1:0] SMP_MAX = '1;

    typedef struct {
        logic [SMP_W-1:0] sample;
        logic [31:0]      time_ms;
    } ecg_item_t;

    typedef struct {
        logic [15:0] bpm;
        logic        rate_valid;
    } rate_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;   // sample, time_ms
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;       // bpm
    logic m_tuser;                        // rate_valid
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    ecg_item_t    sample_q[$];
    rate_result_t rate_expect_q[$];
    ecg_item_t    next_item;
    rate_result_t got_rate;

    // detector state mirrored by the predictor
    logic [SMP_W-1:0]         upper_level;
    logic                     in_beat;
    logic                     first_beat_seen;
    logic [31:0]              last_beat_ms;
    logic [31:0]              beat_gap_ms;
    logic signed [TRAIL_W-1:0] trail_level;

    // stimulus side view of the thresholds and the time cursor
    logic [SMP_W-1:0] gen_upper;
    logic [SMP_W-1:0] gen_lower;
    logic [31:0]      stamp_ms;

    int          send_gap;
    int          stall_left;
    bit          calm;
    int          mismatch_count;
    int          result_count;
    int unsigned cycle_count;

    ecg_heart_rate_detector_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch on result %0d: %s got %0d expected %0d",
                     result_count, what, got, want);
    endtask

    function automatic void reset_detector();
        upper_level     = UPPER_RESET;
        in_beat         = 1'b0;
        first_beat_seen = 1'b0;
        last_beat_ms    = '0;
        beat_gap_ms     = '0;
        trail_level     = TRAIL_W'(1000);
    endfunction

    function automatic void load_threshold(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
        if (idx == REG_UPPER)
            upper_level = val;
        else if (idx == REG_LOWER)
            trail_level = $signed({1'b0, val});
    endfunction

    // rising edge first, then trailing edge against the updated state
    function automatic void predict_rate(input ecg_item_t item);
        rate_result_t res;
        logic signed [TRAIL_W-1:0] level;
        level = $signed({1'b0, item.sample});
        if (item.sample > upper_level && !in_beat)
        begin
            if (!first_beat_seen)
            begin
                trail_level     = level - BEAT_DROP;
                first_beat_seen = 1'b1;
            end
            else
                beat_gap_ms = item.time_ms - last_beat_ms;
            last_beat_ms = item.time_ms;
            in_beat      = 1'b1;
        end
        if (in_beat && level < trail_level)
            in_beat = 1'b0;
        if (beat_gap_ms != 0)
        begin
            res.bpm        = 16'(MINUTE_MS / beat_gap_ms);
            res.rate_valid = 1'b1;
        end
        else
        begin
            res.bpm        = '0;
            res.rate_valid = 1'b0;
        end
        rate_expect_q.push_back(res);
    endfunction

    initial reset_detector();

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap = 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (sample_q.size() > 0)
            begin
                next_item = sample_q.pop_front();
                s_tdata  <= IN_DATA_W'({next_item.time_ms, next_item.sample});
                s_tvalid <= 1'b1;
                send_gap = pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // monitor: check results, predict on accepted samples, track register writes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                result_count++;
                if (rate_expect_q.size() == 0)
                    report_mismatch("unexpected result, bpm", m_tdata, -1);
                else
                begin
                    got_rate = rate_expect_q.pop_front();
                    if (m_tdata[15:0] != got_rate.bpm)
                        report_mismatch("bpm", m_tdata[15:0], got_rate.bpm);
                    if (m_tuser != got_rate.rate_valid)
                        report_mismatch("rate_valid", m_tuser, got_rate.rate_valid);
                end
            end
            if (s_tvalid && s_tready)
                predict_rate('{s_tdata[SMP_W-1:0], s_tdata[SMP_W +: 32]});
            if (cfg_valid && cfg_ready)
                load_threshold(cfg_index, cfg_data);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_UPPER)
            gen_upper = val;
        else if (idx == REG_LOWER)
            gen_lower = val;
    endtask

    // wait until every sample is sent and every result has come, then let the divider settle
    task automatic drain();
        do
            @(negedge clk);
        while (sample_q.size() != 0 || s_tvalid || rate_expect_q.size() != 0);
        repeat (24) @(posedge clk);
    endtask

    function automatic void push_at(input int smp, input logic [31:0] ms);
        stamp_ms = ms;
        sample_q.push_back('{SMP_W'(smp), ms});
    endfunction

    function automatic logic [31:0] next_step();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return 0;
        else if (roll < 55)
            return $urandom_range(1, 20);
        else if (roll < 90)
            return $urandom_range(50, 400);
        else
            return $urandom_range(1000, 90000);
    endfunction

    function automatic void push_next(input int smp);
        push_at(smp, stamp_ms + next_step());
    endfunction

    function automatic int peak_level();
        if (gen_upper == SMP_MAX)
            return SMP_MAX;
        return $urandom_range(int'(gen_upper) + 1, SMP_MAX);
    endfunction

    function automatic int trough_level();
        if (gen_lower == 0)
            return 0;
        return $urandom_range(0, int'(gen_lower) - 1);
    endfunction

    // one heartbeat: low stretch, some random middle samples, then the peak
    function automatic void push_beat();
        repeat ($urandom_range(1, 3)) push_next(trough_level());
        repeat ($urandom_range(0, 2)) push_next($urandom_range(0, SMP_MAX));
        repeat ($urandom_range(1, 2)) push_next(peak_level());
    endfunction

    task automatic random_phase(input int upper, input int lower, input int budget);
        if ($urandom_range(0, 1))
        begin
            write_reg(REG_UPPER, CFG_DATA_W'(upper));
            write_reg(REG_LOWER, CFG_DATA_W'(lower));
        end
        else
        begin
            write_reg(REG_LOWER, CFG_DATA_W'(lower));
            write_reg(REG_UPPER, CFG_DATA_W'(upper));
        end
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                      CFG_DATA_W'($urandom()));
        while (sample_q.size() < budget)
        begin
            if ($urandom_range(0, 9) < 8)
                push_beat();
            else if ($urandom_range(0, 1))
                push_at($urandom_range(0, SMP_MAX), $urandom());
            else
                push_next($urandom_range(0, SMP_MAX));
        end
        drain();
    endtask

    initial
    begin : stimulus
        int upper;
        int lower;
        gen_upper = UPPER_RESET;
        gen_lower = LOWER_RESET;
        stamp_ms  = '0;
        calm      = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first beat at a low level drives the working threshold negative: never leaves
        write_reg(REG_SPARE_A, CFG_DATA_W'($urandom()));
        write_reg(REG_UPPER, CFG_DATA_W'(100));
        push_at(0, 32'd0);
        push_at(100, 32'd1);
        push_at(101, 32'd5);
        push_at(0, 32'd6);
        push_at(SMP_MAX, 32'd7);
        drain();

        // reload the thresholds, then the interval corner cases
        write_reg(REG_UPPER, CFG_DATA_W'(2000));
        write_reg(REG_LOWER, CFG_DATA_W'(1000));
        push_at(0, 32'd10);
        push_at(2000, 32'd20);
        push_at(2001, 32'd1000);
        push_at(999, 32'd1010);
        push_at(2001, 32'd1010);            // beat sharing its timestamp with the sample before
        push_at(0, 32'd1012);
        push_at(SMP_MAX, 32'd1013);         // short interval from the previous beat
        push_at(0, 32'd1014);
        push_at(3000, 32'hFFFF_FFF0);       // interval too long for a nonzero rate
        push_at(0, 32'hFFFF_FFF8);
        push_at(3000, 32'h0000_0010);       // timestamp wraps
        push_at(0, 32'h0000_0011);
        drain();

        // lower threshold above the upper one: enter and leave on one sample
        write_reg(REG_UPPER, CFG_DATA_W'(0));
        write_reg(REG_LOWER, CFG_DATA_W'(SMP_MAX));
        push_at(0, 32'd2000);
        push_at(1, 32'd2100);
        push_at(2, 32'd2150);
        drain();

        // extremes of both registers, then random settings
        for (int ph = 0; ph < 13; ph++)
        begin
            calm = (ph % 4 == 3);
            case (ph)
                0: begin upper = SMP_MAX; lower = 0; end
                1: begin upper = 0; lower = 0; end
                2: begin upper = SMP_MAX; lower = SMP_MAX; end
                3: begin upper = 0; lower = SMP_MAX; end
                default:
                begin
                    upper = $urandom_range(200, 3900);
                    lower = $urandom_range(0, upper);
                    if ($urandom_range(0, 4) == 0)
                        lower = $urandom_range(0, SMP_MAX);
                end
            endcase
            random_phase(upper, lower, $urandom_range(35, 55));
        end
        calm = 1'b0;
        repeat (40) @(posedge clk);

        if (rate_expect_q.size() != 0)
            report_mismatch("results missing", 0, rate_expect_q.size());
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("FAIL");
        $finish;
    end

endmodule
